FILE: hdl/tsg_pkg.sv
// Package for the three servo gait sequencer: types, constants and codes.
package tsg_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int S_TDATA_W  = 56;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 48;

  localparam logic [CFG_ADDR_W-1:0] CFG_FRONT_CENTER = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MID_CENTER   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REAR_CENTER  = 2'd2;

  localparam logic [7:0] FRONT_CENTER_RST = 8'd83;
  localparam logic [7:0] MID_CENTER_RST   = 8'd90;
  localparam logic [7:0] REAR_CENTER_RST  = 8'd80;
  localparam logic [7:0] FRONT_SWING      = 8'd25;
  localparam logic [7:0] MID_SWING        = 8'd13;
  localparam logic [7:0] SERVO_MAX        = 8'd180;

  localparam logic [2:0] PHASE_DONE = 3'd4;
  localparam logic [2:0] PHASE_LAST = 3'd3;

  typedef logic signed [10:0] lim_t;

  localparam lim_t SHAKE_EXTRA = 11'sd10;
  localparam lim_t TURN_OFFSET = 11'sd5;

  typedef enum logic [2:0] {
    GAIT_FWD   = 3'd0,
    GAIT_REV   = 3'd1,
    GAIT_LEFT  = 3'd2,
    GAIT_RIGHT = 3'd3,
    GAIT_SHAKE = 3'd4,
    GAIT_ROCK  = 3'd5
  } gait_t;

  typedef struct packed {
    logic [7:0] front_center;
    logic [7:0] mid_center;
    logic [7:0] rear_center;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] now_ms;
    logic [7:0]  step_angle;
    logic [7:0]  mid_delay;
    logic [7:0]  front_delay;
  } item_t;

  typedef struct packed {
    logic [7:0]  front_angle;
    logic [7:0]  mid_angle;
    logic [2:0]  phase;
    logic [31:0] mid_last_ms;
    logic [31:0] front_last_ms;
    logic [15:0] step_total;
  } state_t;

  typedef struct packed {
    logic [7:0]  front_cmd;
    logic        front_write;
    logic [7:0]  mid_cmd;
    logic        mid_write;
    logic [7:0]  rear_cmd;
    logic        rear_write;
    logic [2:0]  gait_phase;
    logic [15:0] steps_done;
  } result_t;

endpackage

FILE: hdl/three_servo_gait_sequencer_top.sv
// Top level of the three servo gait sequencer: ports, registers and handshake.
// The input register loads at the input transfer; the result register and the gait
// state load when the step advances, which waits while an unaccepted result is held.
// Throughput: one request per cycle unless the output stalls; the single step stage sets it.
// Reset (rst, synchronous): clears both stages, loads the center registers and the
// gait state with their reset values.
module three_servo_gait_sequencer_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tsg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tsg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // now_ms[31:0], step_angle[39:32], mid_delay[47:40], front_delay[55:48]
  input  logic [tsg_pkg::S_TDATA_W-1:0]      s_tdata,
  // req_type[2:0]
  input  logic [tsg_pkg::S_TUSER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // front_cmd[7:0], front_write[8], mid_cmd[16:9], mid_write[17], rear_cmd[25:18],
  // rear_write[26], gait_phase[29:27], steps_done[45:30], zero[47:46]
  output logic [tsg_pkg::M_TDATA_W-1:0]      m_tdata
);
  import tsg_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t out_res;
  logic    out_valid;
  logic    adv;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.steps_done, out_res.gait_phase, out_res.rear_write,
                     out_res.rear_cmd, out_res.mid_write, out_res.mid_cmd,
                     out_res.front_write, out_res.front_cmd};

  tsg_step u_step (
    .cfg  (cfg),
    .item (in_item),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_center <= FRONT_CENTER_RST;
      cfg.mid_center   <= MID_CENTER_RST;
      cfg.rear_center  <= REAR_CENTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRONT_CENTER: cfg.front_center <= cfg_wdata;
        CFG_MID_CENTER:   cfg.mid_center   <= cfg_wdata;
        CFG_REAR_CENTER:  cfg.rear_center  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type    <= s_tuser[2:0];
      in_item.now_ms      <= s_tdata[31:0];
      in_item.step_angle  <= s_tdata[39:32];
      in_item.mid_delay   <= s_tdata[47:40];
      in_item.front_delay <= s_tdata[55:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.front_angle   <= FRONT_CENTER_RST + FRONT_SWING;
      state.mid_angle     <= MID_CENTER_RST - MID_SWING;
      state.phase         <= 3'd0;
      state.mid_last_ms   <= 32'd0;
      state.front_last_ms <= 32'd0;
      state.step_total    <= 16'd0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state.phase <= PHASE_LAST)
    else $error("gait phase left its range");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(state))
    else $error("gait state changed without a step");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (state.step_total == $past(state.step_total)) ||
             ((state.step_total == $past(state.step_total) + 16'd1) && (state.phase == 3'd0)))
    else $error("step count moved wrongly");

  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_res.gait_phase == state.phase && out_res.steps_done == state.step_total)
    else $error("result does not match gait state");

endmodule

FILE: hdl/tsg_step.sv
// Next-state and result logic for one gait request.
module tsg_step (
  input  tsg_pkg::cfg_t    cfg,
  input  tsg_pkg::item_t   item,
  input  tsg_pkg::state_t  cur,
  output tsg_pkg::state_t  nxt,
  output tsg_pkg::result_t res
);
  import tsg_pkg::*;

  function automatic lim_t ext8(input logic [7:0] v);
    ext8 = {3'b000, v};
  endfunction

  function automatic logic [7:0] sat_u8(input logic [7:0] v);
    sat_u8 = (v > SERVO_MAX) ? SERVO_MAX : v;
  endfunction

  function automatic logic [7:0] sat_s11(input lim_t v);
    if (v < 0) begin
      sat_s11 = 8'd0;
    end else if (v > ext8(SERVO_MAX)) begin
      sat_s11 = SERVO_MAX;
    end else begin
      sat_s11 = v[7:0];
    end
  endfunction

  logic [7:0] fmin, fmax, mmin, mmax;
  logic       mid_ok, front_ok;
  logic [2:0] s0, pc;
  logic       mid_second, front_second;
  logic       mid_up, front_up;
  lim_t       mid_lim, front_lim, extra;
  logic [7:0] mid_new, front_new;
  logic       mid_hit, front_hit;
  logic       mid_run, front_run;
  lim_t       rear_val;
  logic [2:0] ph_next;

  assign fmin = cfg.front_center - FRONT_SWING;
  assign fmax = cfg.front_center + FRONT_SWING;
  assign mmin = cfg.mid_center - MID_SWING;
  assign mmax = cfg.mid_center + MID_SWING;

  assign mid_ok   = (item.now_ms - cur.mid_last_ms) > {24'd0, item.mid_delay};
  assign front_ok = (item.now_ms - cur.front_last_ms) > {24'd0, item.front_delay};

  assign s0 = cur.phase;
  assign pc = (cur.phase > 3'd1) ? 3'd0 : cur.phase;
  // each leg moves at most once per request; the mid leg swings back from phase 1, the front from phase 2
  assign mid_second   = (s0 != 3'd0);
  assign front_second = s0[1];

  always_comb begin
    mid_up    = 1'b1;
    mid_lim   = ext8(mmax);
    front_up  = 1'b0;
    front_lim = ext8(fmin);
    extra     = '0;
    unique case (item.req_type)
      GAIT_FWD: begin
        mid_up    = !mid_second;
        mid_lim   = mid_second ? ext8(mmin) : ext8(mmax);
        front_up  = front_second;
        front_lim = front_second ? ext8(fmax) : ext8(fmin);
      end
      GAIT_REV: begin
        mid_up    = !mid_second;
        mid_lim   = mid_second ? ext8(mmin) : ext8(mmax);
        front_up  = !front_second;
        front_lim = front_second ? ext8(fmin) : ext8(fmax);
      end
      GAIT_LEFT: begin
        mid_up    = mid_second;
        mid_lim   = mid_second ? ext8(cfg.mid_center) : ext8(mmin);
        front_up  = !front_second;
        front_lim = front_second ? ext8(fmin) : ext8(fmax);
        extra     = front_second ? -TURN_OFFSET : TURN_OFFSET;
      end
      GAIT_RIGHT: begin
        mid_up    = !mid_second;
        mid_lim   = mid_second ? ext8(cfg.mid_center) : ext8(mmax);
        front_up  = front_second;
        front_lim = front_second ? ext8(fmax) : ext8(fmin);
        extra     = front_second ? TURN_OFFSET : -TURN_OFFSET;
      end
      GAIT_SHAKE: begin
        mid_up  = !pc[0];
        mid_lim = pc[0] ? (ext8(mmin) - SHAKE_EXTRA) : (ext8(mmax) + SHAKE_EXTRA);
      end
      GAIT_ROCK: begin
        front_up  = pc[0];
        front_lim = pc[0] ? ext8(fmax) : ext8(fmin);
      end
      default: begin
      end
    endcase
  end

  assign mid_new   = mid_up ? (cur.mid_angle + item.step_angle)
                            : (cur.mid_angle - item.step_angle);
  assign front_new = front_up ? (cur.front_angle + item.step_angle)
                              : (cur.front_angle - item.step_angle);
  assign mid_hit   = mid_up ? (ext8(mid_new) >= mid_lim) : (ext8(mid_new) <= mid_lim);
  assign front_hit = front_up ? (ext8(front_new) >= front_lim)
                              : (ext8(front_new) <= front_lim);
  assign rear_val  = ext8(front_new) + ext8(cfg.rear_center) - ext8(cfg.front_center) + extra;

  always_comb begin
    nxt       = cur;
    res       = '0;
    mid_run   = 1'b0;
    front_run = 1'b0;
    ph_next   = cur.phase;
    unique case (item.req_type)
      GAIT_FWD, GAIT_REV, GAIT_LEFT, GAIT_RIGHT: begin
        if (s0 <= PHASE_LAST) begin
          if (!s0[0]) begin
            mid_run   = mid_ok;
            front_run = mid_run && mid_hit && front_ok;
          end else begin
            front_run = front_ok;
            mid_run   = front_run && front_hit && (s0 == 3'd1) && mid_ok;
          end
          ph_next = s0 + {2'b00, mid_run && mid_hit} + {2'b00, front_run && front_hit};
        end
        if (ph_next == PHASE_DONE) begin
          ph_next        = 3'd0;
          nxt.step_total = cur.step_total + 16'd1;
        end
      end
      GAIT_SHAKE: begin
        mid_run         = mid_ok;
        ph_next         = (mid_run && mid_hit) ? {2'b00, !pc[0]} : pc;
        res.front_cmd   = sat_u8(cfg.front_center);
        res.front_write = 1'b1;
        res.rear_cmd    = sat_u8(cfg.rear_center);
        res.rear_write  = 1'b1;
      end
      GAIT_ROCK: begin
        front_run     = front_ok;
        ph_next       = (front_run && front_hit) ? {2'b00, !pc[0]} : pc;
        res.mid_cmd   = sat_u8(cfg.mid_center);
        res.mid_write = 1'b1;
      end
      default: begin
      end
    endcase

    if (mid_run) begin
      nxt.mid_angle   = mid_new;
      nxt.mid_last_ms = item.now_ms;
      res.mid_cmd     = sat_u8(mid_new);
      res.mid_write   = 1'b1;
    end
    if (front_run) begin
      nxt.front_angle   = front_new;
      nxt.front_last_ms = item.now_ms;
      res.front_cmd     = sat_u8(front_new);
      res.front_write   = 1'b1;
      res.rear_cmd      = sat_s11(rear_val);
      res.rear_write    = 1'b1;
    end
    nxt.phase      = ph_next;
    res.gait_phase = ph_next;
    res.steps_done = nxt.step_total;
  end

endmodule
